### hdl/pipr_pkg.sv
// Shared types, constants and helpers for the point-in-polygon ray-cast block.
package pipr_pkg;

    // Coordinate, difference and product widths
    localparam int COORD_BITS = 32;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_QUERY_X = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_QUERY_Y = t_cfg_idx'(1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    // One vertex request
    typedef struct packed {
        t_coord vertex_x;
        t_coord vertex_y;
        logic   ring_first;
        logic   ring_last;
        logic   polygon_last;
    } t_vertex;

    // Edge (xi,yi)-(xj,yj) under test
    typedef struct packed {
        t_coord xi;
        t_coord yi;
        t_coord xj;
        t_coord yj;
    } t_edge;

    // Command to the shared cross-multiply unit
    typedef struct packed {
        logic  mul;    // run the multiplier this cycle
        logic  sel_r;  // right-hand product; left-hand otherwise
        t_edge edge_c;
    } t_xu_cmd;

    // Result flags
    typedef struct packed {
        logic contained;
        logic in_outer_ring;
        logic in_some_hole;
    } t_res;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_E1_L,
        ST_E1_R,
        ST_E2_L,
        ST_E2_R,
        ST_FIN
    } t_state;

    // Sign-extended difference a - b, exact
    function automatic t_diff sdiff(input t_coord a, input t_coord b);
        t_diff ea;
        t_diff eb;
        ea = t_diff'(a);
        eb = t_diff'(b);
        return ea - eb;
    endfunction

endpackage

### hdl/pipr_if.sv
// Channel interfaces: vertex requests, result requests and configuration writes.
interface pipr_vtx_if;
    logic                 valid;
    logic                 ready;
    pipr_pkg::t_coord     vertex_x;
    pipr_pkg::t_coord     vertex_y;
    logic                 ring_first;
    logic                 ring_last;
    logic                 polygon_last;

    modport source (output valid, vertex_x, vertex_y, ring_first, ring_last, polygon_last,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, ring_first, ring_last, polygon_last,
                    output ready);
endinterface

interface pipr_res_if;
    logic valid;
    logic ready;
    logic contained;
    logic in_outer_ring;
    logic in_some_hole;

    modport source (output valid, contained, in_outer_ring, in_some_hole, input ready);
    modport sink   (input valid, contained, in_outer_ring, in_some_hole, output ready);
endinterface

interface pipr_cfg_if;
    logic                 valid;
    logic                 ready;
    pipr_pkg::t_cfg_idx   index;
    pipr_pkg::t_coord     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pipr_xunit.sv
// Shared cross-multiply and compare unit for the edge crossing test.
module pipr_xunit (
    input  logic              i_clk,
    input  pipr_pkg::t_xu_cmd i_cmd,
    input  pipr_pkg::t_coord  i_query_x,
    input  pipr_pkg::t_coord  i_query_y,
    output logic              o_cross
);

    pipr_pkg::t_diff w_a;
    pipr_pkg::t_diff w_b;
    pipr_pkg::t_prod w_prod;
    pipr_pkg::t_prod r_prod_l;
    pipr_pkg::t_prod r_prod_r;
    logic            r_dy_neg;
    logic            r_straddle;
    logic            w_straddle;

    // Pick operands: left is (qx-xi)*dy, right is (xj-xi)*(qy-yi)
    always_comb begin
        if (i_cmd.sel_r) begin
            w_a = pipr_pkg::sdiff(i_cmd.edge_c.xj, i_cmd.edge_c.xi);
            w_b = pipr_pkg::sdiff(i_query_y, i_cmd.edge_c.yi);
        end else begin
            w_a = pipr_pkg::sdiff(i_query_x, i_cmd.edge_c.xi);
            w_b = pipr_pkg::sdiff(i_cmd.edge_c.yj, i_cmd.edge_c.yi);
        end
    end

    assign w_prod     = pipr_pkg::t_prod'(w_a) * pipr_pkg::t_prod'(w_b);
    assign w_straddle = (i_cmd.edge_c.yi > i_query_y) != (i_cmd.edge_c.yj > i_query_y);

    // Capture products; keep dy sign and straddle with the left product
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            if (i_cmd.sel_r) begin
                r_prod_r <= w_prod;
            end else begin
                r_prod_l   <= w_prod;
                r_dy_neg   <= w_b[pipr_pkg::DIFF_BITS-1];
                r_straddle <= w_straddle;
            end
        end
    end

    // Compare with the side swapped when dy is negative
    assign o_cross = r_straddle && (r_dy_neg ? (r_prod_r < r_prod_l) : (r_prod_l < r_prod_r));

endmodule

### hdl/pipr_ctrl.sv
// Sequencer and ring state: schedules edges on the shared unit and tracks parity.
module pipr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vtx_valid,
    input  pipr_pkg::t_vertex i_vtx,
    output logic              o_vtx_ready,
    output pipr_pkg::t_xu_cmd o_cmd,
    input  logic              i_cross,
    input  logic              i_res_space,
    output logic              o_push,
    output pipr_pkg::t_res    o_res
);

    pipr_pkg::t_state  r_state;
    pipr_pkg::t_state  n_state;
    pipr_pkg::t_vertex r_v;
    pipr_pkg::t_coord  r_prev_x;
    pipr_pkg::t_coord  r_prev_y;
    pipr_pkg::t_coord  r_start_x;
    pipr_pkg::t_coord  r_start_y;
    logic              r_parity;
    logic              r_outer_done;
    logic              r_outer_inside;
    logic              r_hole_inside;
    logic              r_apply;
    logic              w_accept;
    logic              w_close;
    logic              w_fin;
    logic              w_fin_go;
    logic              w_par_now;
    logic              w_oi_new;
    logic              w_hi_new;

    assign w_accept  = i_vtx_valid && o_vtx_ready;
    assign w_close   = r_v.ring_last || r_v.polygon_last;
    assign w_fin     = (r_state == pipr_pkg::ST_FIN);
    assign w_fin_go  = w_fin && (!r_v.polygon_last || i_res_space);
    assign w_par_now = r_parity ^ (r_apply && i_cross);
    assign w_oi_new  = (w_close && !r_outer_done) ? w_par_now : r_outer_inside;
    assign w_hi_new  = r_hole_inside || (w_close && r_outer_done && w_par_now);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pipr_pkg::ST_IDLE: begin
                if (i_vtx_valid) begin
                    if (!i_vtx.ring_first) begin
                        n_state = pipr_pkg::ST_E1_L;
                    end else if (i_vtx.ring_last || i_vtx.polygon_last) begin
                        n_state = pipr_pkg::ST_E2_L;
                    end else begin
                        n_state = pipr_pkg::ST_FIN;
                    end
                end
            end
            pipr_pkg::ST_E1_L: n_state = pipr_pkg::ST_E1_R;
            pipr_pkg::ST_E1_R: n_state = w_close ? pipr_pkg::ST_E2_L : pipr_pkg::ST_FIN;
            pipr_pkg::ST_E2_L: n_state = pipr_pkg::ST_E2_R;
            pipr_pkg::ST_E2_R: n_state = pipr_pkg::ST_FIN;
            pipr_pkg::ST_FIN: begin
                if (w_fin_go) begin
                    n_state = pipr_pkg::ST_IDLE;
                end
            end
            default: n_state = pipr_pkg::ST_IDLE;
        endcase
    end

    // State outputs: handshake, unit command and edge select
    always_comb begin
        o_vtx_ready  = 1'b0;
        o_cmd.mul    = 1'b0;
        o_cmd.sel_r  = 1'b0;
        o_cmd.edge_c = '{xi: r_start_x, yi: r_start_y, xj: r_v.vertex_x, yj: r_v.vertex_y};
        case (r_state)
            pipr_pkg::ST_IDLE: o_vtx_ready = 1'b1;
            pipr_pkg::ST_E1_L, pipr_pkg::ST_E1_R: begin
                o_cmd.mul    = 1'b1;
                o_cmd.sel_r  = (r_state == pipr_pkg::ST_E1_R);
                o_cmd.edge_c = '{xi: r_v.vertex_x, yi: r_v.vertex_y, xj: r_prev_x, yj: r_prev_y};
            end
            pipr_pkg::ST_E2_L: o_cmd.mul = 1'b1;
            pipr_pkg::ST_E2_R: begin
                o_cmd.mul   = 1'b1;
                o_cmd.sel_r = 1'b1;
            end
            default: o_vtx_ready = 1'b0;
        endcase
    end

    assign o_push            = w_fin && r_v.polygon_last && i_res_space;
    assign o_res.contained     = w_oi_new && !w_hi_new;
    assign o_res.in_outer_ring = w_oi_new;
    assign o_res.in_some_hole  = w_hi_new;

    // Advance state; flag the cycle after a right product as compare-valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pipr_pkg::ST_IDLE;
            r_apply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_apply <= (r_state == pipr_pkg::ST_E1_R) || (r_state == pipr_pkg::ST_E2_R);
        end
    end

    // Hold the accepted vertex
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_v <= i_vtx;
        end
    end

    // Ring and polygon state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_start_x      <= '0;
            r_start_y      <= '0;
            r_parity       <= 1'b0;
            r_outer_done   <= 1'b0;
            r_outer_inside <= 1'b0;
            r_hole_inside  <= 1'b0;
        end else begin
            // open a ring, clear parity when the ring closes, or fold in a crossing
            if (w_accept && i_vtx.ring_first) begin
                r_start_x <= i_vtx.vertex_x;
                r_start_y <= i_vtx.vertex_y;
                r_parity  <= 1'b0;
            end else if (w_fin_go && w_close) begin
                r_parity <= 1'b0;
            end else if (r_apply && i_cross) begin
                r_parity <= !r_parity;
            end
            // retire the vertex: close the ring, drop polygon state after the result
            if (w_fin_go) begin
                r_prev_x <= r_v.vertex_x;
                r_prev_y <= r_v.vertex_y;
                if (r_v.polygon_last) begin
                    r_outer_done   <= 1'b0;
                    r_outer_inside <= 1'b0;
                    r_hole_inside  <= 1'b0;
                end else if (w_close) begin
                    if (!r_outer_done) begin
                        r_outer_inside <= w_par_now;
                        r_outer_done   <= 1'b1;
                    end else if (w_par_now) begin
                        r_hole_inside <= 1'b1;
                    end
                end
            end
        end
    end

    // A compare result is consumed only right after a right-hand product
    a_apply_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_apply |-> (r_state == pipr_pkg::ST_E2_L || r_state == pipr_pkg::ST_FIN))
        else $error("compare consumed outside its slot");

    // A vertex that continues a ring starts with the incoming edge
    a_edge_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_vtx.ring_first) |=> (r_state == pipr_pkg::ST_E1_L))
        else $error("continuing vertex skipped its edge");

    // A hole can only be recorded after the outer ring is closed
    a_hole_after_outer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hole_inside |-> r_outer_done)
        else $error("hole recorded before outer ring");

    // Polygon state is dropped once the result leaves
    a_clear_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (!r_outer_done && !r_hole_inside && !r_outer_inside))
        else $error("polygon state kept after result");

endmodule

### hdl/point_in_polygon_ray_cast.sv
// Top level of the point-in-polygon ray-cast block: config, sequencer, unit, result register.
//
//  channel  dir  payload                                               handshake
//  i_vtx    in   vertex_x, vertex_y, ring_first, ring_last, polygon_last valid/ready
//  i_cfg    in   index (0 query_x, 1 query_y), data                    valid/ready, always ready
//  o_res    out  contained, in_outer_ring, in_some_hole                 valid/ready
//
// A vertex runs a left and a right product for its incoming edge, if any, then for the
// closing edge if it ends a ring: each edge needs two passes through the one shared multiplier.
// The result leaves through an output register; the last cycle of a polygon's final
// vertex waits while that register is full and not taken. i_rst_n is synchronous and
// clears the sequencer, ring state, query point and result valid.
module point_in_polygon_ray_cast (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pipr_vtx_if.sink    i_vtx,
    pipr_cfg_if.sink    i_cfg,
    pipr_res_if.source  o_res
);

    pipr_pkg::t_coord  r_query_x;
    pipr_pkg::t_coord  r_query_y;
    pipr_pkg::t_vertex w_vtx;
    pipr_pkg::t_xu_cmd w_cmd;
    pipr_pkg::t_res    w_res;
    pipr_pkg::t_res    r_res;
    logic              r_res_valid;
    logic              w_cross;
    logic              w_push;
    logic              w_res_space;
    logic              w_vtx_ready;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pipr_pkg::CFG_QUERY_X: r_query_x <= i_cfg.data;
                pipr_pkg::CFG_QUERY_Y: r_query_y <= i_cfg.data;
                default: r_query_x <= r_query_x;
            endcase
        end
    end

    // Vertex request
    assign w_vtx = '{vertex_x:     i_vtx.vertex_x,
                     vertex_y:     i_vtx.vertex_y,
                     ring_first:   i_vtx.ring_first,
                     ring_last:    i_vtx.ring_last,
                     polygon_last: i_vtx.polygon_last};
    assign i_vtx.ready = w_vtx_ready;

    pipr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx_valid (i_vtx.valid),
        .i_vtx       (w_vtx),
        .o_vtx_ready (w_vtx_ready),
        .o_cmd       (w_cmd),
        .i_cross     (w_cross),
        .i_res_space (w_res_space),
        .o_push      (w_push),
        .o_res       (w_res)
    );

    pipr_xunit u_xunit (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_query_x (r_query_x),
        .i_query_y (r_query_y),
        .o_cross   (w_cross)
    );

    // Result register
    assign w_res_space = !r_res_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_push) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.contained     = r_res.contained;
    assign o_res.in_outer_ring = r_res.in_outer_ring;
    assign o_res.in_some_hole  = r_res.in_some_hole;

endmodule
